>>> rtl/igi_pkg.sv
// ----------------------------------------------------------------------------
// igi_pkg
// Shared types and codes of the interval grid index: operation codes,
// register indices, request and response beat layouts.
// ----------------------------------------------------------------------------
package igi_pkg;

   localparam int FIELD_BITS  = 32;
   localparam int MAX_RESULTS = 64;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_QUERY  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;

   localparam logic [1:0] CSR_DOMAIN_START = 2'd0;
   localparam logic [1:0] CSR_DOMAIN_END   = 2'd1;
   localparam logic [1:0] CSR_EXTENT       = 2'd2;
   localparam logic [1:0] CSR_LAST_PART    = 2'd3;

   typedef struct packed {
      logic [1:0]            func;
      logic [FIELD_BITS-1:0] interval_start;
      logic [FIELD_BITS-1:0] interval_end;
      logic [FIELD_BITS-1:0] record_id;
   } igi_req_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] match_id;
      logic                  hit;
      logic                  status;
      logic                  last;
   } igi_rsp_type;

endpackage

>>> rtl/igi_if.sv
// ----------------------------------------------------------------------------
// igi channel interfaces
// Valid/ready channels carrying request and response beats.
// ----------------------------------------------------------------------------
interface igi_req_if;
   logic                 valid;
   logic                 ready;
   igi_pkg::igi_req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface igi_rsp_if;
   logic                 valid;
   logic                 ready;
   igi_pkg::igi_rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/interval_grid_index.sv
// ----------------------------------------------------------------------------
// interval_grid_index
// Grid index of intervals over a time domain: insert, range query, clear.
//
//   channel   dir   beat
//   req_bus   in    func, interval_start, interval_end, record_id
//   rsp_bus   out   match_id, hit, status, last
//   csr_*     in    index + data write, no read-back
//
// One request at a time. Insert and query each run the shared 32-step
// restoring divider twice to find the first and last partition; a query
// outside the domain skips it. Insert then checks every covered partition
// for room and, only if none is full, writes the entry into each of them.
// Query reads each stored entry of the covered partitions from the entry
// memory (S_QRD, then S_QEV on the registered read data) and steps on
// partition by partition. A stalled response beat holds the walk. Reset is
// synchronous and clears all fill counts at once; no clearing pass.
// ----------------------------------------------------------------------------
module interval_grid_index #(
   parameter int NUM_PARTITIONS     = 8,
   parameter int PARTITION_CAPACITY = 8,
   parameter int TIME_BITS          = 32
) (
   input  logic        clock,
   input  logic        reset,
   igi_req_if.sink     req_bus,
   igi_rsp_if.source   rsp_bus,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wr_data
);
   import igi_pkg::*;

   localparam int PW    = $clog2(NUM_PARTITIONS);
   localparam int KW    = (PARTITION_CAPACITY > 1) ? $clog2(PARTITION_CAPACITY) : 1;
   localparam int CW    = $clog2(PARTITION_CAPACITY + 1);
   localparam int TW    = (TIME_BITS < 32) ? TIME_BITS : 32;
   localparam int DEPTH = NUM_PARTITIONS << KW;
   localparam int AW    = PW + KW;
   localparam int MW    = 32 + 2 * TW;
   localparam int BW    = 38;
   localparam int NW    = $clog2(MAX_RESULTS + 1);
   localparam logic [31:0] TMASK = (TIME_BITS >= 32) ? 32'hFFFF_FFFF
                                 : 32'((64'd1 << TIME_BITS) - 64'd1);
   localparam logic [PW-1:0] TOP_MAX = PW'(NUM_PARTITIONS - 1);
   localparam logic [CW-1:0] CAP     = CW'(PARTITION_CAPACITY);

   typedef enum logic [9:0] {
      S_IDLE = 10'b00_0000_0001,
      S_DIVS = 10'b00_0000_0010,
      S_DIVE = 10'b00_0000_0100,
      S_BASE = 10'b00_0000_1000,
      S_CHK  = 10'b00_0001_0000,
      S_WR   = 10'b00_0010_0000,
      S_QRD  = 10'b00_0100_0000,
      S_QEV  = 10'b00_1000_0000,
      S_QFIN = 10'b01_0000_0000,
      S_RESP = 10'b10_0000_0000
   } state_type;

   // configuration
   logic [31:0] dstart_ff, dend_ff, ext_ff;
   logic [3:0]  lpart_ff;

   // control
   state_type                  state_ff, state_in;
   logic [NUM_PARTITIONS-1:0][CW-1:0] fill_ff, fill_in;
   logic                       is_ins_ff, is_ins_in;
   logic [31:0]                qs_ff, qs_in, qe_ff, qe_in, id_ff, id_in;
   logic [31:0]                ce_ff, ce_in;
   logic                       ae_s_ff, ae_s_in, ae_e_ff, ae_e_in;
   logic                       ce_low_ff, ce_low_in;
   logic [32:0]                rem_ff, rem_in;
   logic [31:0]                quo_ff, quo_in;
   logic [4:0]                 dcnt_ff, dcnt_in;
   logic [PW-1:0]              sp_ff, sp_in, ep_ff, ep_in, cur_ff, cur_in;
   logic [CW-1:0]              k_ff, k_in;
   logic [BW-1:0]              pbase_ff, pbase_in;
   logic [NW-1:0]              n_ff, n_in;
   logic [31:0]                pend_ff, pend_in;
   logic                       stat_ff, stat_in;
   logic                       rsp_vld_ff, rsp_vld_in;
   igi_rsp_type                rsp_ff, rsp_in;

   // entry memory
   logic [MW-1:0] mem [DEPTH];
   logic [MW-1:0] rd_data_ff;
   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;

   // combinational helpers
   logic [PW-1:0] top;
   logic [31:0]   divisor, s_m, e_m, cs, ce, quo_fin;
   logic [32:0]   shl;
   logic          ge, out_free, take, ov, fresh;
   logic [31:0]   ent_id, ent_start, ent_end;
   logic [PW-1:0] qpart;

   assign top = (32'(lpart_ff) > 32'(NUM_PARTITIONS - 1)) ? TOP_MAX : lpart_ff[PW-1:0];
   assign divisor = (ext_ff == 32'd0) ? 32'd1 : ext_ff;
   assign shl     = {rem_ff[31:0], quo_ff[31]};
   assign ge      = shl >= {1'b0, divisor};
   assign quo_fin = {quo_ff[30:0], ge};
   assign qpart   = (quo_fin > 32'(top)) ? top : quo_fin[PW-1:0];

   assign s_m = req_bus.payload.interval_start & TMASK;
   assign e_m = req_bus.payload.interval_end & TMASK;
   assign cs  = (s_m > dstart_ff) ? s_m : dstart_ff;
   assign ce  = (e_m < dend_ff) ? e_m : dend_ff;

   assign ent_id    = rd_data_ff[MW-1 -: 32];
   assign ent_start = 32'(rd_data_ff[2*TW-1:TW]);
   assign ent_end   = 32'(rd_data_ff[TW-1:0]);
   assign ov        = (ent_start <= qe_ff) && (qs_ff <= ent_end);
   assign fresh     = BW'(ent_start) >= pbase_ff;
   always_comb begin
      if (cur_ff == sp_ff) begin
         take = ov;
      end else if (cur_ff < ep_ff) begin
         take = fresh;
      end else begin
         take = fresh && ov;
      end
   end

   assign out_free      = !rsp_vld_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign rsp_bus.valid = rsp_vld_ff;
   assign rsp_bus.payload = rsp_ff;

   assign rd_addr = {cur_ff, k_ff[KW-1:0]};
   assign wr_addr = {cur_ff, fill_ff[cur_ff][KW-1:0]};

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      is_ins_in = is_ins_ff;
      qs_in     = qs_ff;
      qe_in     = qe_ff;
      id_in     = id_ff;
      ce_in     = ce_ff;
      ae_s_in   = ae_s_ff;
      ae_e_in   = ae_e_ff;
      ce_low_in = ce_low_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dcnt_in   = dcnt_ff;
      sp_in     = sp_ff;
      ep_in     = ep_ff;
      cur_in    = cur_ff;
      k_in      = k_ff;
      pbase_in  = pbase_ff;
      n_in      = n_ff;
      pend_in   = pend_ff;
      stat_in   = stat_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_bus.ready;
      rsp_in    = rsp_ff;
      rd_en     = 1'b0;
      wr_en     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               qs_in   = s_m;
               qe_in   = e_m;
               id_in   = req_bus.payload.record_id;
               stat_in = 1'b0;
               n_in    = '0;
               ce_in   = ce;
               ce_low_in = ce < dstart_ff;
               rem_in  = '0;
               quo_in  = cs - dstart_ff;
               dcnt_in = '0;
               unique case (req_bus.payload.func)
                  FUNC_INSERT: begin
                     is_ins_in = 1'b1;
                     ae_s_in   = s_m == dend_ff;
                     ae_e_in   = e_m == dend_ff;
                     state_in  = S_DIVS;
                  end
                  FUNC_QUERY: begin
                     is_ins_in = 1'b0;
                     ae_s_in   = cs == dend_ff;
                     ae_e_in   = ce == dend_ff;
                     if (s_m <= dend_ff && e_m >= dstart_ff && s_m <= e_m) begin
                        state_in = S_DIVS;
                     end else begin
                        state_in = S_QFIN;
                     end
                  end
                  FUNC_CLEAR: begin
                     fill_in  = '0;
                     state_in = S_RESP;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_DIVS: begin
            rem_in  = ge ? shl - {1'b0, divisor} : shl;
            quo_in  = quo_fin;
            dcnt_in = dcnt_ff + 5'd1;
            if (dcnt_ff == 5'd31) begin
               sp_in   = ae_s_ff ? top : qpart;
               rem_in  = '0;
               quo_in  = ce_ff - dstart_ff;
               dcnt_in = '0;
               state_in = S_DIVE;
            end
         end
         S_DIVE: begin
            rem_in  = ge ? shl - {1'b0, divisor} : shl;
            quo_in  = quo_fin;
            dcnt_in = dcnt_ff + 5'd1;
            if (dcnt_ff == 5'd31) begin
               if (ae_e_ff) begin
                  ep_in = top;
               end else if (ce_low_ff) begin
                  ep_in = '0;
               end else begin
                  ep_in = qpart;
               end
               cur_in = sp_ff;
               if (is_ins_ff) begin
                  // reversed insert covers only its start partition
                  if (ep_in < sp_ff) begin
                     ep_in = sp_ff;
                  end
                  state_in = S_CHK;
               end else begin
                  state_in = S_BASE;
               end
            end
         end
         S_CHK: begin
            if (fill_ff[cur_ff] >= CAP) begin
               stat_in  = 1'b1;
               state_in = S_RESP;
            end else if (cur_ff == ep_ff) begin
               cur_in   = sp_ff;
               state_in = S_WR;
            end else begin
               cur_in = cur_ff + PW'(1);
            end
         end
         S_WR: begin
            wr_en = 1'b1;
            fill_in[cur_ff] = fill_ff[cur_ff] + CW'(1);
            if (cur_ff == ep_ff) begin
               state_in = S_RESP;
            end else begin
               cur_in = cur_ff + PW'(1);
            end
         end
         S_BASE: begin
            pbase_in = BW'(dstart_ff) + BW'(sp_ff) * BW'(ext_ff);
            k_in     = '0;
            state_in = S_QRD;
         end
         S_QRD: begin
            if (k_ff >= fill_ff[cur_ff]) begin
               if (cur_ff == ep_ff) begin
                  state_in = S_QFIN;
               end else begin
                  cur_in   = cur_ff + PW'(1);
                  k_in     = '0;
                  pbase_in = pbase_ff + BW'(ext_ff);
               end
            end else begin
               rd_en    = 1'b1;
               state_in = S_QEV;
            end
         end
         S_QEV: begin
            if (take && n_ff < NW'(MAX_RESULTS)) begin
               // a new match releases the one held back
               if (n_ff == '0 || out_free) begin
                  if (n_ff != '0) begin
                     rsp_vld_in = 1'b1;
                     rsp_in     = '{match_id: pend_ff, hit: 1'b1, status: 1'b0, last: 1'b0};
                  end
                  pend_in  = ent_id;
                  n_in     = n_ff + NW'(1);
                  k_in     = k_ff + CW'(1);
                  state_in = S_QRD;
               end
            end else begin
               k_in     = k_ff + CW'(1);
               state_in = S_QRD;
            end
         end
         S_QFIN: begin
            if (out_free) begin
               rsp_vld_in = 1'b1;
               if (n_ff == '0) begin
                  rsp_in = '{match_id: 32'd0, hit: 1'b0, status: 1'b0, last: 1'b1};
               end else begin
                  rsp_in = '{match_id: pend_ff, hit: 1'b1, status: 1'b0, last: 1'b1};
               end
               state_in = S_IDLE;
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_vld_in = 1'b1;
               rsp_in     = '{match_id: 32'd0, hit: 1'b0, status: stat_ff, last: 1'b1};
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         fill_ff    <= '0;
         rsp_vld_ff <= 1'b0;
         dstart_ff  <= 32'd0;
         dend_ff    <= 32'hFFFF_FFFF;
         ext_ff     <= 32'd536870912;
         lpart_ff   <= 4'd7;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         rsp_vld_ff <= rsp_vld_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_DOMAIN_START: dstart_ff <= csr_wr_data;
               CSR_DOMAIN_END:   dend_ff   <= csr_wr_data;
               CSR_EXTENT:       ext_ff    <= csr_wr_data;
               CSR_LAST_PART:    lpart_ff  <= csr_wr_data[3:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      is_ins_ff <= is_ins_in;
      qs_ff     <= qs_in;
      qe_ff     <= qe_in;
      id_ff     <= id_in;
      ce_ff     <= ce_in;
      ae_s_ff   <= ae_s_in;
      ae_e_ff   <= ae_e_in;
      ce_low_ff <= ce_low_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      dcnt_ff   <= dcnt_in;
      sp_ff     <= sp_in;
      ep_ff     <= ep_in;
      cur_ff    <= cur_in;
      k_ff      <= k_in;
      pbase_ff  <= pbase_in;
      n_ff      <= n_in;
      pend_ff   <= pend_in;
      stat_ff   <= stat_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {id_ff, qs_ff[TW-1:0], qe_ff[TW-1:0]};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

`ifndef SYNTHESIS
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WR) |-> (fill_ff[cur_ff] < CAP))
      else $error("write into a full partition");

   a_match_cap: assert property (@(posedge clock) disable iff (reset)
      n_ff <= NW'(MAX_RESULTS))
      else $error("match count beyond limit");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && req_bus.payload.func == FUNC_CLEAR)
      |=> (fill_ff == '0))
      else $error("clear left entries behind");
`endif

endmodule

>>> test/igi_grid_monitor.sv
// ----------------------------------------------------------------------------
// igi_grid_monitor
// Watches the request, response and register ports of the interval grid
// index. It keeps its own copy of the partition grid, works out the response
// beats of every accepted request and compares them in order with the beats
// the block sends.
// ----------------------------------------------------------------------------
module igi_grid_monitor #(
   parameter int PARTS    = 8,
   parameter int CAPACITY = 8
) (
   input  logic        clock,
   input  logic        reset,
   igi_req_if          req_bus,
   igi_rsp_if          rsp_bus,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wr_data,
   output int          fails,
   output int          pending,
   output int          beats_seen,
   output int          hits_seen,
   output int          rejects_seen
);
   import igi_pkg::*;

   logic [31:0] dom_lo, dom_hi, extent;
   logic [3:0]  last_part;
   logic [31:0] slot_id [PARTS*CAPACITY];
   logic [31:0] slot_lo [PARTS*CAPACITY];
   logic [31:0] slot_hi [PARTS*CAPACITY];
   int          fill [PARTS];
   igi_rsp_type due_beats [$];

   task automatic report(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      fails++;
   endtask

   task automatic add_beat(input igi_rsp_type b);
      due_beats.insert(due_beats.size(), b);
   endtask

   function automatic int top_cell();
      return (last_part > PARTS - 1) ? PARTS - 1 : int'(last_part);
   endfunction

   function automatic int grid_cell(input logic [63:0] cv, input bit at_end);
      logic [63:0] step, v;
      if (at_end) return top_cell();
      if (cv < {32'd0, dom_lo}) return 0;
      step = (extent == 0) ? 64'd1 : {32'd0, extent};
      v = (cv - {32'd0, dom_lo}) / step;
      if (v > top_cell()) v = top_cell();
      return int'(v);
   endfunction

   function automatic igi_rsp_type beat(input logic [31:0] id, input logic h,
                                        input logic st, input logic lst);
      igi_rsp_type b;
      b.match_id = id;
      b.hit      = h;
      b.status   = st;
      b.last     = lst;
      return b;
   endfunction

   task automatic apply_request(input igi_req_type r);
      logic [63:0] s, e, cs, ce, cell_lo;
      int          sp, ep, slot, n;
      bit          full, ov, fresh, take;
      s = {32'd0, r.interval_start};
      e = {32'd0, r.interval_end};
      n = 0;
      case (r.func)
         FUNC_INSERT: begin
            sp = grid_cell((s > dom_lo) ? s : {32'd0, dom_lo}, s == dom_hi);
            ep = grid_cell((e < dom_hi) ? e : {32'd0, dom_hi}, e == dom_hi);
            if (ep < sp) ep = sp;
            full = 0;
            for (int p = sp; p <= ep; p++) if (fill[p] >= CAPACITY) full = 1;
            if (!full) begin
               for (int p = sp; p <= ep; p++) begin
                  slot = p * CAPACITY + fill[p];
                  slot_id[slot] = r.record_id;
                  slot_lo[slot] = r.interval_start;
                  slot_hi[slot] = r.interval_end;
                  fill[p]++;
               end
            end
            add_beat(beat('0, 1'b0, full, 1'b1));
         end
         FUNC_QUERY: begin
            if (s <= dom_hi && e >= dom_lo && s <= e) begin
               cs = (s > dom_lo) ? s : {32'd0, dom_lo};
               ce = (e < dom_hi) ? e : {32'd0, dom_hi};
               sp = grid_cell(cs, cs == dom_hi);
               ep = grid_cell(ce, ce == dom_hi);
               for (int p = sp; p <= ep && p < PARTS; p++) begin
                  cell_lo = {32'd0, dom_lo} + 64'(p) * {32'd0, extent};
                  for (int k = 0; k < fill[p] && k < CAPACITY; k++) begin
                     slot  = p * CAPACITY + k;
                     ov    = slot_lo[slot] <= e && s <= slot_hi[slot];
                     fresh = {32'd0, slot_lo[slot]} >= cell_lo;
                     // first cell: overlap, middle cells: start inside, last: both
                     if (p == sp) take = ov;
                     else if (p < ep) take = fresh;
                     else take = fresh && ov;
                     if (take && n < MAX_RESULTS) begin
                        add_beat(beat(slot_id[slot], 1'b1, 1'b0, 1'b0));
                        n++;
                     end
                  end
               end
            end
            if (n == 0) add_beat(beat('0, 1'b0, 1'b0, 1'b1));
            else due_beats[due_beats.size() - 1].last = 1'b1;
         end
         FUNC_CLEAR: begin
            for (int p = 0; p < PARTS; p++) fill[p] = 0;
            add_beat(beat('0, 1'b0, 1'b0, 1'b1));
         end
         default: add_beat(beat('0, 1'b0, 1'b0, 1'b1));
      endcase
   endtask

   always @(posedge clock) begin
      igi_rsp_type got, want;
      if (reset) begin
         dom_lo    = 32'd0;
         dom_hi    = 32'hFFFF_FFFF;
         extent    = 32'd536870912;
         last_part = 4'd7;
         for (int p = 0; p < PARTS; p++) fill[p] = 0;
         due_beats.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = rsp_bus.payload;
            beats_seen++;
            if (got.hit) hits_seen++;
            if (got.status) rejects_seen++;
            if (due_beats.size() == 0) begin
               report($sformatf("response beat id %h with nothing expected", got.match_id));
            end else begin
               want = due_beats.pop_front();
               if (got.match_id !== want.match_id)
                  report($sformatf("match_id %h, expected %h", got.match_id, want.match_id));
               if (got.hit !== want.hit)
                  report($sformatf("hit %b, expected %b", got.hit, want.hit));
               if (got.status !== want.status)
                  report($sformatf("status %b, expected %b", got.status, want.status));
               if (got.last !== want.last)
                  report($sformatf("last %b, expected %b", got.last, want.last));
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_DOMAIN_START: dom_lo = csr_wr_data;
               CSR_DOMAIN_END:   dom_hi = csr_wr_data;
               CSR_EXTENT:       extent = csr_wr_data;
               CSR_LAST_PART:    last_part = csr_wr_data[3:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) apply_request(req_bus.payload);
      end
      pending = due_beats.size();
   end

endmodule

>>> test/tb_interval_grid_index.sv
// ----------------------------------------------------------------------------
// tb_interval_grid_index
// Drives inserts, range queries, clears and unused codes into the grid
// index under several domain settings, with random gaps on both channels. A
// monitor beside the block predicts every response beat and counts mismatches.
// ----------------------------------------------------------------------------
module tb_interval_grid_index;
   import igi_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [31:0] csr_wr_data;
   logic        steady;
   logic [31:0] lo_mirror, hi_mirror;
   int          fails, pending, beats_seen, hits_seen, rejects_seen;
   int          sent [4];

   igi_req_if req_bus ();
   igi_rsp_if rsp_bus ();

   interval_grid_index dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   igi_grid_monitor monitor (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data),
      .fails        (fails),
      .pending      (pending),
      .beats_seen   (beats_seen),
      .hits_seen    (hits_seen),
      .rejects_seen (rejects_seen)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_bus.ready <= !reset && (steady || $urandom_range(99) >= 21);
   end

   initial begin
      #50_000_000;
      $display("tb_interval_grid_index NOT OK");
      $finish;
   end

   task automatic issue(input logic [1:0] f, input logic [31:0] s, input logic [31:0] e,
                        input logic [31:0] id);
      while (!steady && $urandom_range(99) < 21) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid                  <= 1'b1;
      req_bus.payload.func           <= f;
      req_bus.payload.interval_start <= s;
      req_bus.payload.interval_end   <= e;
      req_bus.payload.record_id      <= id;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent[f]++;
   endtask

   // wait until every expected beat is in, then let the block go quiet
   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_domain(input logic [31:0] lo, input logic [31:0] hi,
                             input logic [31:0] ext, input logic [3:0] lp);
      logic [31:0] vals [4];
      settle();
      vals = '{lo, hi, ext, {28'd0, lp}};
      for (int i = 0; i < 4; i++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= 2'(i);
         csr_wr_data <= vals[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      lo_mirror = lo;
      hi_mirror = hi;
   endtask

   function automatic logic [31:0] pick_stamp();
      logic [63:0] span;
      int          k;
      k = $urandom_range(99);
      if (k < 8) return $urandom;
      if (k < 14) return lo_mirror;
      if (k < 20) return hi_mirror;
      if (k < 25) return lo_mirror - 32'd1;
      if (k < 30) return hi_mirror + 32'($urandom_range(3));
      span = (hi_mirror >= lo_mirror) ? {32'd0, hi_mirror - lo_mirror} + 64'd1 : 64'd1;
      return 32'({32'd0, lo_mirror} + ({$urandom, $urandom} % span));
   endfunction

   task automatic random_traffic(input int count);
      logic [31:0] a, b, t;
      logic [1:0]  f;
      int          k;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(99);
         if (k < 55) f = FUNC_INSERT;
         else if (k < 91) f = FUNC_QUERY;
         else if (k < 97) f = FUNC_CLEAR;
         else f = FUNC_UNUSED;
         a = pick_stamp();
         b = pick_stamp();
         if ($urandom_range(99) < 85 && a > b) begin
            t = a;
            a = b;
            b = t;
         end
         issue(f, a, b, $urandom);
      end
   endtask

   // domain 1000..1799, eight cells of 100
   task automatic directed_cases();
      issue(FUNC_INSERT, 32'd1000, 32'd1099, 32'd0);
      issue(FUNC_INSERT, 32'd1799, 32'd1799, 32'hFFFF_FFFF);
      issue(FUNC_INSERT, 32'd0, 32'hFFFF_FFFF, 32'd1);
      issue(FUNC_INSERT, 32'd1500, 32'd1200, 32'd2);
      issue(FUNC_INSERT, 32'd1850, 32'd1900, 32'd3);
      issue(FUNC_INSERT, 32'd10, 32'd20, 32'd4);
      // fill cell zero to capacity, then one more is refused
      for (int i = 0; i < 5; i++) issue(FUNC_INSERT, 32'd1050, 32'd1060, 32'(10 + i));
      issue(FUNC_INSERT, 32'd1070, 32'd1080, 32'd99);
      issue(FUNC_QUERY, 32'd1000, 32'd1799, 32'd0);
      issue(FUNC_QUERY, 32'd1400, 32'd1450, 32'd0);
      issue(FUNC_QUERY, 32'd1800, 32'd1900, 32'd0);
      issue(FUNC_QUERY, 32'd1500, 32'd1400, 32'd0);
      issue(FUNC_QUERY, 32'd0, 32'd999, 32'd0);
      issue(FUNC_QUERY, 32'd0, 32'hFFFF_FFFF, 32'd0);
      issue(FUNC_CLEAR, 32'd0, 32'd0, 32'd0);
      issue(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue(FUNC_QUERY, 32'd1000, 32'd1799, 32'd0);
   endtask

   initial begin
      clock               = 1'b0;
      reset               = 1'b1;
      steady              = 1'b0;
      csr_wr_en           = 1'b0;
      csr_index           = '0;
      csr_wr_data         = '0;
      req_bus.valid       = 1'b0;
      req_bus.payload     = '0;
      lo_mirror           = 32'd0;
      hi_mirror           = 32'hFFFF_FFFF;
      sent                = '{0, 0, 0, 0};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      random_traffic(40);
      set_domain(32'd1000, 32'd1799, 32'd100, 4'd7);
      directed_cases();
      random_traffic(80);
      // zero extent acts as one, index saturates at cell 3
      set_domain(32'd50, 32'd80, 32'd0, 4'd3);
      random_traffic(70);
      set_domain(32'hFFFF_FF00, 32'hFFFF_FFFF, 32'd32, 4'd15);
      random_traffic(70);
      set_domain(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0);
      random_traffic(60);
      set_domain(32'd200, 32'd999, 32'd100, 4'd7);
      steady <= 1'b1;
      random_traffic(60);
      steady <= 1'b0;
      random_traffic(70);

      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (300) @(posedge clock);

      $display("requests: %0d inserts, %0d queries, %0d clears, %0d unused codes",
               sent[0], sent[1], sent[2], sent[3]);
      $display("response beats: %0d, matches %0d, refused inserts %0d",
               beats_seen, hits_seen, rejects_seen);
      if (fails == 0 && pending == 0) begin
         $display("tb_interval_grid_index OK");
      end else begin
         if (pending != 0) $display("%0d expected beats never arrived", pending);
         $display("tb_interval_grid_index NOT OK");
      end
      $finish;
   end

endmodule
